// ----- src/keypad_setpoint_controller_core_assert.svh -----
// ----------------------------------------------------------------------------
// Keypad setpoint controller assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_SETPOINT_CONTROLLER_CORE_ASSERT_SVH
`define KEYPAD_SETPOINT_CONTROLLER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KPSC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("kpsc: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define KPSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("kpsc: next-cycle check failed");

`endif

// ----- src/kpsc_pkg.sv -----
// ----------------------------------------------------------------------------
// Keypad setpoint controller package
// Shared types, key codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package kpsc_pkg;

	// Field widths.
	localparam int KeyW      = 3;
	localparam int StepW     = 8;
	localparam int LimitW    = 10;
	localparam int IdW       = 8;
	localparam int SetpointW = 11;
	localparam int CfgIdxW   = 3;
	localparam int CfgDataW  = 10;

	// Key codes.
	localparam logic [KeyW-1:0] KEY_DIR  = 3'd1;
	localparam logic [KeyW-1:0] KEY_DOWN = 3'd2;
	localparam logic [KeyW-1:0] KEY_UP   = 3'd3;
	localparam logic [KeyW-1:0] KEY_MODE = 3'd4;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] REG_RPM_STEP   = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_RPM_LIMIT  = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_ID_CEILING = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_INITIAL_ID = 3'd3;

	// Register reset values.
	localparam logic [StepW-1:0]  RPM_STEP_RST   = 8'd20;
	localparam logic [LimitW-1:0] RPM_LIMIT_RST  = 10'd280;
	localparam logic [IdW-1:0]    ID_CEILING_RST = 8'd247;
	localparam logic [IdW-1:0]    INITIAL_ID_RST = 8'd1;

	// Function mode selected by key four.
	typedef enum logic [1:0] {
		MODE_SPEED  = 2'd0,
		MODE_ID     = 2'd1,
		MODE_REMOTE = 2'd2
	} mode_t;

	// Configuration register contents.
	typedef struct packed {
		logic [StepW-1:0]  rpm_step;
		logic [LimitW-1:0] rpm_limit;
		logic [IdW-1:0]    id_ceiling;
		logic [IdW-1:0]    initial_id;
	} cfg_t;

	// Load of the device address from a write to initial_id.
	typedef struct packed {
		logic           load;
		logic [IdW-1:0] value;
	} id_load_t;

	// Panel state carried from one key event to the next.
	typedef struct packed {
		mode_t                       mode;
		logic                        dir_rev;
		logic signed [SetpointW-1:0] setpoint;
		logic [IdW-1:0]              dev_addr;
		logic                        remote_sel;
	} panel_state_t;

endpackage

// ----- src/kpsc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Keypad setpoint controller configuration registers
// Holds step, limit, id ceiling and initial id; flags initial id loads.
// ----------------------------------------------------------------------------
module kpsc_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [kpsc_pkg::CfgIdxW-1:0]    wr_index,
	input  logic [kpsc_pkg::CfgDataW-1:0]   wr_data,
	output kpsc_pkg::cfg_t                  cfg,
	output kpsc_pkg::id_load_t              id_load
);

	kpsc_pkg::cfg_t cfg_q;

	// Register file; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rpm_step   <= kpsc_pkg::RPM_STEP_RST;
			cfg_q.rpm_limit  <= kpsc_pkg::RPM_LIMIT_RST;
			cfg_q.id_ceiling <= kpsc_pkg::ID_CEILING_RST;
			cfg_q.initial_id <= kpsc_pkg::INITIAL_ID_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				kpsc_pkg::REG_RPM_STEP:   cfg_q.rpm_step   <= wr_data[kpsc_pkg::StepW-1:0];
				kpsc_pkg::REG_RPM_LIMIT:  cfg_q.rpm_limit  <= wr_data[kpsc_pkg::LimitW-1:0];
				kpsc_pkg::REG_ID_CEILING: cfg_q.id_ceiling <= wr_data[kpsc_pkg::IdW-1:0];
				kpsc_pkg::REG_INITIAL_ID: cfg_q.initial_id <= wr_data[kpsc_pkg::IdW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

	// A write to initial_id also reloads the device address at once.
	assign id_load.load  = wr_en && (wr_index == kpsc_pkg::REG_INITIAL_ID);
	assign id_load.value = wr_data[kpsc_pkg::IdW-1:0];

endmodule

// ----- src/kpsc_step.sv -----
// ----------------------------------------------------------------------------
// Keypad setpoint controller key step
// Next panel state and the id write request for one key event.
// ----------------------------------------------------------------------------
module kpsc_step (
	input  logic [kpsc_pkg::KeyW-1:0] key,
	input  kpsc_pkg::panel_state_t    cur,
	input  kpsc_pkg::cfg_t            cfg,
	output kpsc_pkg::panel_state_t    nxt,
	output logic                      id_write
);

	localparam int SumW = kpsc_pkg::SetpointW + 2;

	kpsc_pkg::mode_t         mode_new;
	logic signed [SumW-1:0]  sp_ext;
	logic signed [SumW-1:0]  step_ext;
	logic signed [SumW-1:0]  lim_ext;
	logic signed [SumW-1:0]  sum;
	logic signed [SumW-1:0]  clamped;
	logic                    step_add;
	logic [kpsc_pkg::IdW:0]  id_inc;
	logic [kpsc_pkg::IdW-1:0] id_up;
	logic [kpsc_pkg::IdW-1:0] id_down;

	// Key four advances the function mode before the other keys act.
	always_comb begin
		mode_new = cur.mode;
		if (key == kpsc_pkg::KEY_MODE) begin
			unique case (cur.mode)
				kpsc_pkg::MODE_SPEED:  mode_new = kpsc_pkg::MODE_ID;
				kpsc_pkg::MODE_ID:     mode_new = kpsc_pkg::MODE_REMOTE;
				kpsc_pkg::MODE_REMOTE: mode_new = kpsc_pkg::MODE_SPEED;
				default:               mode_new = kpsc_pkg::MODE_SPEED;
			endcase
		end
	end

	// Setpoint step: up key adds along the direction, down key subtracts.
	always_comb begin
		sp_ext   = SumW'(cur.setpoint);
		step_ext = $signed({{(SumW-kpsc_pkg::StepW){1'b0}}, cfg.rpm_step});
		lim_ext  = $signed({{(SumW-kpsc_pkg::LimitW){1'b0}}, cfg.rpm_limit});
		step_add = (key == kpsc_pkg::KEY_UP) ^ cur.dir_rev;
		sum      = step_add ? (sp_ext + step_ext) : (sp_ext - step_ext);
		clamped  = sum;
		if (!cur.dir_rev) begin
			if (sum < 0) clamped = '0;
			if (sum > lim_ext) clamped = lim_ext;
		end else begin
			if (sum > 0) clamped = '0;
			if (sum < -lim_ext) clamped = -lim_ext;
		end
	end

	// Address stepping with floor one and ceiling id_ceiling.
	always_comb begin
		id_inc  = {1'b0, cur.dev_addr} + 1'b1;
		id_up   = (id_inc > {1'b0, cfg.id_ceiling}) ? cfg.id_ceiling
		                                            : id_inc[kpsc_pkg::IdW-1:0];
		id_down = (cur.dev_addr <= kpsc_pkg::IdW'(1)) ? kpsc_pkg::IdW'(1)
		                                             : cur.dev_addr - 1'b1;
	end

	// Key dispatch on the updated mode.
	always_comb begin
		nxt      = cur;
		nxt.mode = mode_new;
		id_write = 1'b0;
		unique case (mode_new)
			kpsc_pkg::MODE_SPEED: begin
				if (!cur.remote_sel) begin
					if (key == kpsc_pkg::KEY_DIR) begin
						nxt.dir_rev  = ~cur.dir_rev;
						nxt.setpoint = '0;
					end else if (key == kpsc_pkg::KEY_DOWN || key == kpsc_pkg::KEY_UP) begin
						nxt.setpoint = clamped[kpsc_pkg::SetpointW-1:0];
					end
				end
			end
			kpsc_pkg::MODE_ID: begin
				if (key == kpsc_pkg::KEY_DOWN) begin
					nxt.dev_addr = id_down;
					id_write     = 1'b1;
				end else if (key == kpsc_pkg::KEY_UP) begin
					nxt.dev_addr = id_up;
					id_write     = 1'b1;
				end
			end
			default: begin
				if (key == kpsc_pkg::KEY_DOWN) begin
					nxt.remote_sel = 1'b0;
				end else if (key == kpsc_pkg::KEY_UP) begin
					nxt.remote_sel = 1'b1;
				end
			end
		endcase
	end

endmodule

// ----- src/keypad_setpoint_controller_core.sv -----
// ----------------------------------------------------------------------------
// Keypad setpoint controller core
// Key-driven front panel: function mode, direction, setpoint, id, local/remote.
// ----------------------------------------------------------------------------
// Each key beat produces exactly one result beat carrying the full panel state
// after that key. A beat enters an input register; once the result register is
// free or draining, the single-pass step logic updates the panel state and loads
// the result register, so one key beat can be taken every cycle while m_tready
// is high; the rate is set by the state update loop. The input side keeps
// accepting while a result waits, as long as the input register drains.
// Configuration writes are accepted every cycle; writing initial_id also reloads
// the device address. Write configuration only while no key beat is in flight.
module keypad_setpoint_controller_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// Key input stream.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,   // [2:0] key
	// Result stream.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [1:0] function_mode, [2] reverse_dir, [13:3] setpoint_rpm,
	// [21:14] device_id, [22] remote_mode, [23] id_write
	output logic [23:0]                         m_tdata,
	// Configuration write channel.
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [kpsc_pkg::CfgIdxW-1:0]        cfg_index,
	input  logic [kpsc_pkg::CfgDataW-1:0]       cfg_data
);

	kpsc_pkg::cfg_t         cfg;
	kpsc_pkg::id_load_t     id_load;
	kpsc_pkg::panel_state_t state_q;
	kpsc_pkg::panel_state_t state_nxt;
	logic                   id_write_nxt;

	logic                          valid_s1;
	logic [kpsc_pkg::KeyW-1:0]     key_s1;
	logic                          adv;
	logic                          out_valid_q;
	logic [23:0]                   out_data_q;

	assign cfg_ready = 1'b1;

	kpsc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg),
		.id_load  (id_load)
	);

	kpsc_step u_step (
		.key      (key_s1),
		.cur      (state_q),
		.cfg      (cfg),
		.nxt      (state_nxt),
		.id_write (id_write_nxt)
	);

	// Stage one moves on when the result register is free or being drained.
	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			key_s1 <= s_tdata[kpsc_pkg::KeyW-1:0];
		end
	end

	// Panel state; a write to initial_id reloads the device address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode       <= kpsc_pkg::MODE_SPEED;
			state_q.dir_rev    <= 1'b0;
			state_q.setpoint   <= '0;
			state_q.dev_addr   <= kpsc_pkg::INITIAL_ID_RST;
			state_q.remote_sel <= 1'b0;
		end else if (id_load.load) begin
			state_q.dev_addr <= id_load.value;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= {id_write_nxt, state_nxt.remote_sel, state_nxt.dev_addr,
			               state_nxt.setpoint, state_nxt.dir_rev, state_nxt.mode};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Assertions.
	`include "keypad_setpoint_controller_core_assert.svh"

	// Forward running never shows a negative setpoint.
	`KPSC_ASSERT_SAME(a_fwd_sign, clk, arst_n,
		m_tvalid && !m_tdata[2], !m_tdata[13])
	// Reverse running never shows a positive setpoint.
	`KPSC_ASSERT_SAME(a_rev_sign, clk, arst_n,
		m_tvalid && m_tdata[2], m_tdata[13] || (m_tdata[13:3] == 11'd0))
	// A nonvolatile write is only requested in id mode.
	`KPSC_ASSERT_SAME(a_idw_mode, clk, arst_n,
		m_tvalid && m_tdata[23], m_tdata[1:0] == kpsc_pkg::MODE_ID)
	// A stage-one advance always presents a result next cycle.
	`KPSC_ASSERT_NEXT(a_adv_out, clk, arst_n, adv, m_tvalid)

endmodule

// ----- dv/keypad_setpoint_controller_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keypad setpoint controller core testbench
// Sends key beats under random sender and receiver stalls, predicts the panel
// state that each key leaves behind, and checks every result beat field by
// field against the oldest prediction. Directed keys and register extremes
// come first, then random key traffic under several register settings.
// ----------------------------------------------------------------------------
module keypad_setpoint_controller_core_tb;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;

	// Key codes that have no function.
	localparam logic [kpsc_pkg::KeyW-1:0] KEY_NONE = 3'd0;
	localparam logic [kpsc_pkg::KeyW-1:0] KEY_TOP  = '1;

	// One result beat, laid out as on m_tdata.
	typedef struct packed {
		logic                                  id_write;
		logic                                  remote_mode;
		logic [kpsc_pkg::IdW-1:0]              device_id;
		logic signed [kpsc_pkg::SetpointW-1:0] setpoint_rpm;
		logic                                  reverse_dir;
		kpsc_pkg::mode_t                       function_mode;
	} panel_result_t;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          s_tvalid  = 1'b0;
	logic                          s_tready;
	logic [7:0]                    s_tdata   = '0;
	logic                          m_tvalid;
	logic                          m_tready  = 1'b0;
	logic [23:0]                   m_tdata;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [kpsc_pkg::CfgIdxW-1:0]  cfg_index = '0;
	logic [kpsc_pkg::CfgDataW-1:0] cfg_data  = '0;

	// Predicted panel state and register contents.
	kpsc_pkg::mode_t pnl_mode     = kpsc_pkg::MODE_SPEED;
	logic            pnl_rev      = 1'b0;
	int              pnl_setpoint = 0;
	int unsigned     pnl_addr     = 32'(kpsc_pkg::INITIAL_ID_RST);
	logic            pnl_remote   = 1'b0;
	int unsigned     step_amt     = 32'(kpsc_pkg::RPM_STEP_RST);
	int unsigned     speed_limit  = 32'(kpsc_pkg::RPM_LIMIT_RST);
	int unsigned     id_max       = 32'(kpsc_pkg::ID_CEILING_RST);

	panel_result_t expected_panels[$];
	int            errors      = 0;
	int            cycle_count = 0;
	int            tx_idle_pct = 0;
	int            rx_idle_pct = 0;

	keypad_setpoint_controller_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Give up on a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Receiver stalls at the rate of the current phase.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// Keep the setpoint inside the range of the current direction.
	function automatic int clamp_to_direction(input int v);
		int lim;
		lim = int'(speed_limit);
		if (!pnl_rev) begin
			if (v < 0) v = 0;
			if (v > lim) v = lim;
		end else begin
			if (v > 0) v = 0;
			if (v < -lim) v = -lim;
		end
		return v;
	endfunction

	// Apply one key to the predicted panel and return the result it reports.
	function automatic panel_result_t press_key(input logic [kpsc_pkg::KeyW-1:0] key);
		panel_result_t r;
		int            delta;
		r = '0;
		if (key == kpsc_pkg::KEY_MODE) begin
			case (pnl_mode)
				kpsc_pkg::MODE_SPEED: pnl_mode = kpsc_pkg::MODE_ID;
				kpsc_pkg::MODE_ID:    pnl_mode = kpsc_pkg::MODE_REMOTE;
				default:              pnl_mode = kpsc_pkg::MODE_SPEED;
			endcase
		end
		case (pnl_mode)
			kpsc_pkg::MODE_SPEED: begin
				if (!pnl_remote) begin
					delta = pnl_rev ? -int'(step_amt) : int'(step_amt);
					if (key == kpsc_pkg::KEY_DIR) begin
						pnl_rev      = ~pnl_rev;
						pnl_setpoint = 0;
					end else if (key == kpsc_pkg::KEY_DOWN) begin
						pnl_setpoint = clamp_to_direction(pnl_setpoint - delta);
					end else if (key == kpsc_pkg::KEY_UP) begin
						pnl_setpoint = clamp_to_direction(pnl_setpoint + delta);
					end
				end
			end
			kpsc_pkg::MODE_ID: begin
				if (key == kpsc_pkg::KEY_DOWN) begin
					pnl_addr   = (pnl_addr <= 1) ? 1 : pnl_addr - 1;
					r.id_write = 1'b1;
				end else if (key == kpsc_pkg::KEY_UP) begin
					pnl_addr   = (pnl_addr + 1 > id_max) ? id_max : pnl_addr + 1;
					r.id_write = 1'b1;
				end
			end
			default: begin
				if (key == kpsc_pkg::KEY_DOWN) pnl_remote = 1'b0;
				else if (key == kpsc_pkg::KEY_UP) pnl_remote = 1'b1;
			end
		endcase
		r.function_mode = pnl_mode;
		r.reverse_dir   = pnl_rev;
		r.setpoint_rpm  = pnl_setpoint[kpsc_pkg::SetpointW-1:0];
		r.device_id     = pnl_addr[kpsc_pkg::IdW-1:0];
		r.remote_mode   = pnl_remote;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		errors++;
	endtask

	// Compare each result beat with the oldest predicted panel.
	always @(posedge clk) begin : check_results
		panel_result_t got;
		panel_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (expected_panels.size() == 0) begin
				report_mismatch("result beat with nothing expected", int'(m_tdata), 0);
			end else begin
				want = expected_panels.pop_front();
				if (got.function_mode !== want.function_mode)
					report_mismatch("function_mode", int'(got.function_mode),
						int'(want.function_mode));
				if (got.reverse_dir !== want.reverse_dir)
					report_mismatch("reverse_dir", int'(got.reverse_dir),
						int'(want.reverse_dir));
				if (got.setpoint_rpm !== want.setpoint_rpm)
					report_mismatch("setpoint_rpm", int'(got.setpoint_rpm),
						int'(want.setpoint_rpm));
				if (got.device_id !== want.device_id)
					report_mismatch("device_id", int'(got.device_id), int'(want.device_id));
				if (got.remote_mode !== want.remote_mode)
					report_mismatch("remote_mode", int'(got.remote_mode),
						int'(want.remote_mode));
				if (got.id_write !== want.id_write)
					report_mismatch("id_write", int'(got.id_write), int'(want.id_write));
			end
		end
	end

	// Send one key beat, with random idle cycles ahead of it, and predict its result.
	task automatic send_key(input logic [kpsc_pkg::KeyW-1:0] key);
		if ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(8-kpsc_pkg::KeyW){1'b0}}, key};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_panels.push_back(press_key(key));
	endtask

	// Write one register; the last write of a batch drops valid.
	task automatic write_register(input logic [kpsc_pkg::CfgIdxW-1:0] idx,
			input logic [kpsc_pkg::CfgDataW-1:0] data, input bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			kpsc_pkg::REG_RPM_STEP:   step_amt    = 32'(data[kpsc_pkg::StepW-1:0]);
			kpsc_pkg::REG_RPM_LIMIT:  speed_limit = 32'(data[kpsc_pkg::LimitW-1:0]);
			kpsc_pkg::REG_ID_CEILING: id_max      = 32'(data[kpsc_pkg::IdW-1:0]);
			kpsc_pkg::REG_INITIAL_ID: pnl_addr    = 32'(data[kpsc_pkg::IdW-1:0]);
			default: ;
		endcase
		if (last) cfg_valid <= 1'b0;
	endtask

	// Hold off the sender until every predicted result has been checked.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_panels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic select_mode(input kpsc_pkg::mode_t m);
		while (pnl_mode != m) send_key(kpsc_pkg::KEY_MODE);
	endtask

	// Unused key codes leave the panel alone.
	task automatic test_unused_keys();
		send_key(KEY_NONE);
		for (int k = int'(kpsc_pkg::KEY_MODE) + 1; k <= int'(KEY_TOP); k++)
			send_key(k[kpsc_pkg::KeyW-1:0]);
	endtask

	// Setpoint steps and clamps in both directions at the reset settings.
	task automatic test_speed_keys();
		select_mode(kpsc_pkg::MODE_SPEED);
		send_key(kpsc_pkg::KEY_UP);
		send_key(kpsc_pkg::KEY_DOWN);
		send_key(kpsc_pkg::KEY_DOWN);
		send_key(kpsc_pkg::KEY_DIR);
		send_key(kpsc_pkg::KEY_UP);
		send_key(kpsc_pkg::KEY_UP);
		send_key(kpsc_pkg::KEY_DOWN);
		send_key(kpsc_pkg::KEY_DOWN);
		send_key(kpsc_pkg::KEY_DIR);
	endtask

	// Address floor, increments, and a key with no meaning in id mode.
	task automatic test_id_keys();
		select_mode(kpsc_pkg::MODE_ID);
		send_key(kpsc_pkg::KEY_DOWN);
		send_key(kpsc_pkg::KEY_UP);
		send_key(kpsc_pkg::KEY_UP);
		send_key(kpsc_pkg::KEY_DIR);
	endtask

	// Remote control locks out the speed keys until local is chosen again.
	task automatic test_remote_select();
		select_mode(kpsc_pkg::MODE_REMOTE);
		send_key(kpsc_pkg::KEY_UP);
		select_mode(kpsc_pkg::MODE_SPEED);
		send_key(kpsc_pkg::KEY_UP);
		send_key(kpsc_pkg::KEY_DIR);
		send_key(kpsc_pkg::KEY_DOWN);
		select_mode(kpsc_pkg::MODE_REMOTE);
		send_key(kpsc_pkg::KEY_DOWN);
		select_mode(kpsc_pkg::MODE_SPEED);
	endtask

	// Largest and smallest register values, and writes to unused indexes.
	task automatic test_register_extremes();
		drain_results();
		write_register(kpsc_pkg::REG_RPM_STEP, '1, 1'b0);
		write_register(kpsc_pkg::REG_RPM_LIMIT, 10'd1000, 1'b1);
		select_mode(kpsc_pkg::MODE_SPEED);
		repeat (5) send_key(kpsc_pkg::KEY_UP);
		send_key(kpsc_pkg::KEY_DIR);
		repeat (5) send_key(kpsc_pkg::KEY_UP);
		drain_results();
		write_register(kpsc_pkg::REG_RPM_LIMIT, '1, 1'b1);
		repeat (2) send_key(kpsc_pkg::KEY_UP);
		send_key(kpsc_pkg::KEY_DOWN);
		drain_results();
		write_register(kpsc_pkg::REG_RPM_STEP, '0, 1'b0);
		write_register(kpsc_pkg::REG_RPM_LIMIT, '0, 1'b1);
		send_key(kpsc_pkg::KEY_UP);
		send_key(kpsc_pkg::KEY_DIR);
		send_key(kpsc_pkg::KEY_DOWN);

		// Address saturation at the top, and a ceiling of zero.
		drain_results();
		write_register(kpsc_pkg::REG_ID_CEILING, 10'd255, 1'b0);
		write_register(kpsc_pkg::REG_INITIAL_ID, 10'd255, 1'b1);
		select_mode(kpsc_pkg::MODE_ID);
		send_key(kpsc_pkg::KEY_UP);
		send_key(kpsc_pkg::KEY_DOWN);
		repeat (2) send_key(kpsc_pkg::KEY_UP);
		drain_results();
		write_register(kpsc_pkg::REG_ID_CEILING, '0, 1'b1);
		send_key(kpsc_pkg::KEY_UP);
		repeat (2) send_key(kpsc_pkg::KEY_DOWN);

		// Loaded address above the ceiling falls to the ceiling on the next up.
		drain_results();
		write_register(kpsc_pkg::REG_ID_CEILING, 10'd100, 1'b0);
		write_register(kpsc_pkg::REG_INITIAL_ID, 10'd200, 1'b1);
		send_key(kpsc_pkg::KEY_UP);

		// Unused indexes must not touch any register.
		drain_results();
		for (int i = int'(kpsc_pkg::REG_INITIAL_ID) + 1; i < (1 << kpsc_pkg::CfgIdxW); i++)
			write_register(i[kpsc_pkg::CfgIdxW-1:0],
				(i[0] ? '1 : kpsc_pkg::CfgDataW'($urandom)), 1'b0);
		write_register(kpsc_pkg::REG_RPM_STEP, 10'd20, 1'b1);
		send_key(kpsc_pkg::KEY_UP);
		select_mode(kpsc_pkg::MODE_SPEED);
		send_key(kpsc_pkg::KEY_UP);
	endtask

	// Mostly meaningful keys with a little noise; down slightly favored.
	function automatic logic [kpsc_pkg::KeyW-1:0] random_key();
		int r;
		r = $urandom_range(99);
		if (r < 10) return kpsc_pkg::KEY_MODE;
		if (r < 16)
			return $urandom_range(1) ? KEY_NONE : kpsc_pkg::KeyW'($urandom_range(
				int'(kpsc_pkg::KEY_MODE) + 1, int'(KEY_TOP)));
		if (r < 26) return kpsc_pkg::KEY_DIR;
		if (r < 62) return kpsc_pkg::KEY_UP;
		return kpsc_pkg::KEY_DOWN;
	endfunction

	// Random key traffic in chunks, with new register settings between chunks.
	task automatic test_random_traffic(input int chunks, input int keys_per_chunk);
		bit load_id;
		for (int c = 0; c < chunks; c++) begin
			drain_results();
			load_id = ($urandom_range(2) == 0);
			write_register(kpsc_pkg::REG_RPM_STEP, kpsc_pkg::CfgDataW'(
				($urandom_range(9) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 50)),
				1'b0);
			write_register(kpsc_pkg::REG_RPM_LIMIT, kpsc_pkg::CfgDataW'(
				($urandom_range(9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 300)),
				1'b0);
			write_register(kpsc_pkg::REG_ID_CEILING, kpsc_pkg::CfgDataW'(
				($urandom_range(2) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 12)),
				!load_id);
			if (load_id)
				write_register(kpsc_pkg::REG_INITIAL_ID,
					kpsc_pkg::CfgDataW'($urandom_range(1, 255)), 1'b1);
			repeat (keys_per_chunk) send_key(random_key());
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 18;
		rx_idle_pct = 69;
		test_unused_keys();
		test_speed_keys();
		test_id_keys();
		test_remote_select();
		test_register_extremes();
		test_random_traffic(5, 66);

		drain_results();
		tx_idle_pct = 69;
		rx_idle_pct = 18;
		test_random_traffic(5, 66);

		drain_results();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random_traffic(5, 66);

		drain_results();
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
